@@ rtl/lclg_pkg.sv @@
// ----------------------------------------------------------------------------
// lclg_pkg
// Shared types and codes for the Life change-list generation block.
// ----------------------------------------------------------------------------
`default_nettype none

package lclg_pkg;

    localparam int GRID_ROWS = 64;
    localparam int GRID_COLS = 64;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_GEN   = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [5:0] row;
        logic [5:0] col;
        logic       alive;
    } cmd_t;

    typedef struct packed {
        logic        cell_alive;
        logic [3:0]  neighbour_count;
        logic [12:0] changed_count;
        logic        status;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR_CHK,
        ST_RD_CHK,
        ST_BUMP_RD,
        ST_BUMP_WR,
        ST_G_QRD,
        ST_G_QWAIT,
        ST_G_NRD,
        ST_G_NCHK,
        ST_F_QRD,
        ST_F_QWAIT,
        ST_F_CCHK
    } state_t;

endpackage

`default_nettype wire

@@ rtl/life_change_list_generation_top.sv @@
// ----------------------------------------------------------------------------
// life_change_list_generation_top
// Conway Life grid (B3/S23) stepped through a change list held in memory.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) takes one transaction at a time:
//   write a cell, run one generation, or read a cell. Every transaction gives
//   exactly one rsp transaction (rsp_valid / rsp_stall / rsp).
//   Cell state lives in one single-port-read RAM (alive, mark, count), with
//   the change and candidate queues in two further RAMs.
//   A read checks the cell and answers; a write reads the cell, flips it, then
//   reads and writes each of its neighbours inside the grid. A generation scans
//   the 3x3 block around each queued cell, then flips each candidate and
//   updates its neighbours; all of this shares the single cell-store RAM port.
//   One transaction is worked at a time; cmd_stall is high while busy or while
//   a response waits in the output register.
//   After reset a clearing pass zeroes all ROWS*COLS cells of the grid while
//   cmd_stall stays high.
//   When the receiver stalls, rsp holds and no new command is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module life_change_list_generation_top
    import lclg_pkg::*;
#(
    parameter int ROWS = GRID_ROWS,
    parameter int COLS = GRID_COLS
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    output logic      cmd_stall,
    input  wire cmd_t cmd,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    localparam int TOTAL = ROWS * COLS;
    localparam int AW    = $clog2(TOTAL);
    localparam int CW    = $clog2(TOTAL + 1);
    localparam int RW    = $clog2(ROWS);
    localparam int CLW   = $clog2(COLS);
    localparam int QW    = RW + CLW;

    // storage
    logic [5:0]    cell_mem [TOTAL];
    logic [QW-1:0] chg_mem  [TOTAL];
    logic [QW-1:0] cnd_mem  [TOTAL];

    logic [5:0]    cell_rdata_reg;
    logic [QW-1:0] chg_rdata_reg;
    logic [QW-1:0] cnd_rdata_reg;

    logic [AW-1:0] cell_ra, cell_wa;
    logic          cell_we;
    logic [5:0]    cell_wd;
    logic [AW-1:0] chg_ra, chg_wa, cnd_ra, cnd_wa;
    logic          chg_we, cnd_we;
    logic [QW-1:0] chg_wd, cnd_wd;

    // control
    state_t         state_reg, state_next;
    logic [AW-1:0]  clr_reg, clr_next;
    logic [CW-1:0]  chg_cnt_reg, chg_cnt_next;
    logic [CW-1:0]  cnd_cnt_reg, cnd_cnt_next;
    logic [CW-1:0]  q_reg, q_next;
    logic [RW-1:0]  r_reg, r_next;
    logic [CLW-1:0] c_reg, c_next;
    logic [1:0]     dr_reg, dr_next, dc_reg, dc_next;
    logic           want_reg, want_next;
    logic           gen_reg, gen_next;
    logic           rsp_valid_reg, rsp_valid_next;
    rsp_t           rsp_reg, rsp_next;

    function automatic logic [AW-1:0] cidx(input logic [RW-1:0] r, input logic [CLW-1:0] c);
        return AW'(32'(r) * COLS + 32'(c));
    endfunction

    // neighbour under the 3x3 iterator, offsets are dr-1 and dc-1
    logic [RW:0]    sr;
    logic [CLW:0]   sc;
    logic           nb_ok, centre, last;
    logic [RW-1:0]  nr;
    logic [CLW-1:0] nc;
    logic [AW-1:0]  nb_idx;
    logic [1:0]     dr_adv, dc_adv;
    logic           cmd_inside;
    logic [RW-1:0]  cmd_r;
    logic [CLW-1:0] cmd_c;
    logic [5:0]     v;
    logic           ns;

    always_comb
    begin
        sr     = {1'b0, r_reg} + (RW+1)'(dr_reg);
        sc     = {1'b0, c_reg} + (CLW+1)'(dc_reg);
        nb_ok  = (sr != '0) && (32'(sr) <= ROWS) && (sc != '0) && (32'(sc) <= COLS);
        nr     = RW'(sr - (RW+1)'(1));
        nc     = CLW'(sc - (CLW+1)'(1));
        nb_idx = cidx(nr, nc);
        centre = (dr_reg == 2'd1) && (dc_reg == 2'd1);
        last   = (dr_reg == 2'd2) && (dc_reg == 2'd2);
        if (dc_reg == 2'd2)
        begin
            dc_adv = 2'd0;
            dr_adv = dr_reg + 2'd1;
        end
        else
        begin
            dc_adv = dc_reg + 2'd1;
            dr_adv = dr_reg;
        end
        cmd_inside = (32'(cmd.row) < ROWS) && (32'(cmd.col) < COLS);
        cmd_r      = RW'(cmd.row);
        cmd_c      = CLW'(cmd.col);
        v          = cell_rdata_reg;
        // B3/S23
        ns         = (v[5:2] == 4'd3) || ((v[5:2] == 4'd2) && v[0]);
    end

    assign cmd_stall = !((state_reg == ST_IDLE) && !rsp_valid_reg);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        chg_cnt_next   = chg_cnt_reg;
        cnd_cnt_next   = cnd_cnt_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        dr_next        = dr_reg;
        dc_next        = dc_reg;
        want_next      = want_reg;
        gen_next       = gen_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        cell_ra = nb_idx;
        cell_we = 1'b0;
        cell_wa = nb_idx;
        cell_wd = '0;
        chg_ra  = q_reg[AW-1:0];
        chg_we  = 1'b0;
        chg_wa  = q_reg[AW-1:0];
        chg_wd  = {r_reg, c_reg};
        cnd_ra  = q_reg[AW-1:0];
        cnd_we  = 1'b0;
        cnd_wa  = cnd_cnt_reg[AW-1:0];
        cnd_wd  = {nr, nc};

        unique case (state_reg)
            ST_CLEAR:
            begin
                cell_we = 1'b1;
                cell_wa = clr_reg;
                clr_next = clr_reg + AW'(1);
                if (32'(clr_reg) == TOTAL - 1)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                cell_ra = cidx(cmd_r, cmd_c);
                if (cmd_valid && !cmd_stall)
                begin
                    r_next    = cmd_r;
                    c_next    = cmd_c;
                    want_next = cmd.alive;
                    rsp_next  = '0;
                    unique case (cmd.mode)
                        MODE_WRITE:
                        begin
                            if (cmd_inside)
                                state_next = ST_WR_CHK;
                            else
                                rsp_valid_next = 1'b1;
                        end
                        MODE_READ:
                        begin
                            if (cmd_inside)
                                state_next = ST_RD_CHK;
                            else
                                rsp_valid_next = 1'b1;
                        end
                        MODE_GEN:
                        begin
                            cnd_cnt_next = '0;
                            q_next       = '0;
                            state_next   = ST_G_QRD;
                        end
                        default:
                            rsp_valid_next = 1'b1;
                    endcase
                end
            end
            ST_RD_CHK:
            begin
                rsp_next.cell_alive      = v[0];
                rsp_next.neighbour_count = v[5:2];
                rsp_valid_next           = 1'b1;
                state_next               = ST_IDLE;
            end
            ST_WR_CHK:
            begin
                if (v[0] == want_reg)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (32'(chg_cnt_reg) >= TOTAL)
                begin
                    rsp_next.status = 1'b1;
                    rsp_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    cell_we      = 1'b1;
                    cell_wa      = cidx(r_reg, c_reg);
                    cell_wd      = v ^ 6'd1;
                    chg_we       = 1'b1;
                    chg_wa       = chg_cnt_reg[AW-1:0];
                    chg_cnt_next = chg_cnt_reg + CW'(1);
                    gen_next     = 1'b0;
                    dr_next      = '0;
                    dc_next      = '0;
                    state_next   = ST_BUMP_RD;
                end
            end
            ST_BUMP_RD:
            begin
                if (nb_ok && !centre)
                    state_next = ST_BUMP_WR;
                else if (!last)
                begin
                    dr_next = dr_adv;
                    dc_next = dc_adv;
                end
                else if (gen_reg)
                begin
                    q_next     = q_reg + CW'(1);
                    state_next = ST_F_QRD;
                end
                else
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_BUMP_WR:
            begin
                cell_we = 1'b1;
                cell_wd = want_reg ? v + 6'd4 : v - 6'd4;
                dr_next = dr_adv;
                dc_next = dc_adv;
                if (!last)
                    state_next = ST_BUMP_RD;
                else if (gen_reg)
                begin
                    q_next     = q_reg + CW'(1);
                    state_next = ST_F_QRD;
                end
                else
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_G_QRD:
            begin
                if (q_reg < chg_cnt_reg)
                    state_next = ST_G_QWAIT;
                else
                begin
                    q_next     = '0;
                    state_next = ST_F_QRD;
                end
            end
            ST_G_QWAIT:
            begin
                r_next     = chg_rdata_reg[QW-1:CLW];
                c_next     = chg_rdata_reg[CLW-1:0];
                dr_next    = '0;
                dc_next    = '0;
                state_next = ST_G_NRD;
            end
            ST_G_NRD:
            begin
                if (nb_ok)
                    state_next = ST_G_NCHK;
                else if (last)
                begin
                    q_next     = q_reg + CW'(1);
                    state_next = ST_G_QRD;
                end
                else
                begin
                    dr_next = dr_adv;
                    dc_next = dc_adv;
                end
            end
            ST_G_NCHK:
            begin
                // marked cells are already queued
                if (!v[1] && (ns != v[0]) && (32'(cnd_cnt_reg) < TOTAL))
                begin
                    cell_we      = 1'b1;
                    cell_wd      = v | 6'd2;
                    cnd_we       = 1'b1;
                    cnd_cnt_next = cnd_cnt_reg + CW'(1);
                end
                dr_next = dr_adv;
                dc_next = dc_adv;
                if (last)
                begin
                    q_next     = q_reg + CW'(1);
                    state_next = ST_G_QRD;
                end
                else
                    state_next = ST_G_NRD;
            end
            ST_F_QRD:
            begin
                if (q_reg < cnd_cnt_reg)
                    state_next = ST_F_QWAIT;
                else
                begin
                    chg_cnt_next           = cnd_cnt_reg;
                    rsp_next.changed_count = 13'(cnd_cnt_reg);
                    rsp_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            ST_F_QWAIT:
            begin
                r_next     = cnd_rdata_reg[QW-1:CLW];
                c_next     = cnd_rdata_reg[CLW-1:0];
                cell_ra    = cidx(cnd_rdata_reg[QW-1:CLW], cnd_rdata_reg[CLW-1:0]);
                state_next = ST_F_CCHK;
            end
            ST_F_CCHK:
            begin
                cell_we    = 1'b1;
                cell_wa    = cidx(r_reg, c_reg);
                cell_wd    = (v ^ 6'd1) & ~6'd2;
                want_next  = !v[0];
                chg_we     = 1'b1;
                gen_next   = 1'b1;
                dr_next    = '0;
                dc_next    = '0;
                state_next = ST_BUMP_RD;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            chg_cnt_reg   <= '0;
            cnd_cnt_reg   <= '0;
            q_reg         <= '0;
            dr_reg        <= '0;
            dc_reg        <= '0;
            gen_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            chg_cnt_reg   <= chg_cnt_next;
            cnd_cnt_reg   <= cnd_cnt_next;
            q_reg         <= q_next;
            dr_reg        <= dr_next;
            dc_reg        <= dc_next;
            gen_reg       <= gen_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg    <= r_next;
        c_reg    <= c_next;
        want_reg <= want_next;
        rsp_reg  <= rsp_next;
    end

    // RAMs, registered read
    always_ff @(posedge clk)
    begin
        if (cell_we)
            cell_mem[cell_wa] <= cell_wd;
        cell_rdata_reg <= cell_mem[cell_ra];
    end

    always_ff @(posedge clk)
    begin
        if (chg_we)
            chg_mem[chg_wa] <= chg_wd;
        chg_rdata_reg <= chg_mem[chg_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cnd_we)
            cnd_mem[cnd_wa] <= cnd_wd;
        cnd_rdata_reg <= cnd_mem[cnd_ra];
    end

endmodule

`default_nettype wire

@@ tb/sv/life_change_list_generation_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_change_list_generation_top_test
// Self-checking bench for the Life change-list generation block: cell
// writes, generations and reads are driven through the command channel and
// every response is compared with a predicted grid kept in the bench.
// ----------------------------------------------------------------------------

import lclg_pkg::*;

// Predicted grid plus the queue of responses still to come.
class life_scoreboard;
    bit          alive_map [4096];
    bit          mark_map  [4096];
    int unsigned nb_count  [4096];
    int unsigned change_list [$];
    rsp_t        pending_rsp [$];
    int          errors;

    function new();
        errors = 0;
    endfunction

    function void bump(int r, int c, bit up);
        int nr;
        int nc;
        for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++)
            begin
                nr = r + dr;
                nc = c + dc;
                if ((dr != 0 || dc != 0) && nr >= 0 && nc >= 0 && nr < GRID_ROWS
                    && nc < GRID_COLS)
                begin
                    if (up)
                        nb_count[nr * GRID_COLS + nc] += 1;
                    else
                        nb_count[nr * GRID_COLS + nc] -= 1;
                end
            end
    endfunction

    function int unsigned step_generation();
        int unsigned flips [$];
        int r;
        int c;
        int k;
        bit next_alive;
        foreach (change_list[q])
        begin
            r = change_list[q] / GRID_COLS;
            c = change_list[q] % GRID_COLS;
            for (int dr = -1; dr <= 1; dr++)
                for (int dc = -1; dc <= 1; dc++)
                    if (r + dr >= 0 && c + dc >= 0 && r + dr < GRID_ROWS
                        && c + dc < GRID_COLS)
                    begin
                        k = (r + dr) * GRID_COLS + c + dc;
                        next_alive = (nb_count[k] == 3)
                                     || (nb_count[k] == 2 && alive_map[k]);
                        if (!mark_map[k] && next_alive != alive_map[k])
                        begin
                            mark_map[k] = 1'b1;
                            flips.push_back(k);
                        end
                    end
        end
        foreach (flips[q])
        begin
            k = flips[q];
            mark_map[k] = 1'b0;
            alive_map[k] = !alive_map[k];
            bump(k / GRID_COLS, k % GRID_COLS, alive_map[k]);
        end
        change_list = flips;
        return flips.size();
    endfunction

    // Note an accepted command and predict its response.
    function void note_command(cmd_t c);
        rsp_t e;
        int   k;
        e = '0;
        k = c.row * GRID_COLS + c.col;
        case (c.mode)
            MODE_WRITE:
                if (alive_map[k] != c.alive)
                begin
                    if (change_list.size() >= GRID_ROWS * GRID_COLS)
                        e.status = 1'b1;
                    else
                    begin
                        alive_map[k] = c.alive;
                        bump(c.row, c.col, c.alive);
                        change_list.push_back(k);
                    end
                end
            MODE_GEN:
                e.changed_count = 13'(step_generation());
            MODE_READ:
            begin
                e.cell_alive = alive_map[k];
                e.neighbour_count = 4'(nb_count[k]);
            end
            default: ;
        endcase
        pending_rsp.push_back(e);
    endfunction

    task report(string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    task check_response(rsp_t got);
        rsp_t e;
        if (pending_rsp.size() == 0)
        begin
            report("response with none pending");
            return;
        end
        e = pending_rsp.pop_front();
        if (got.cell_alive != e.cell_alive)
            report($sformatf("cell_alive %0d exp %0d", got.cell_alive, e.cell_alive));
        if (got.neighbour_count != e.neighbour_count)
            report($sformatf("neighbour_count %0d exp %0d", got.neighbour_count,
                             e.neighbour_count));
        if (got.changed_count != e.changed_count)
            report($sformatf("changed_count %0d exp %0d", got.changed_count,
                             e.changed_count));
        if (got.status != e.status)
            report($sformatf("status %0d exp %0d", got.status, e.status));
    endtask
endclass

module life_change_list_generation_top_test;

    localparam int WATCHDOG_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    cmd_t cmd;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    life_scoreboard board;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_off;
    int  quiet_cycles;
    bit  timed_out;

    life_change_list_generation_top uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Responses are sampled on the rising edge; the scoreboard sees each
    // accepted transaction in that order.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            board.check_response(rsp);
    end

    // Receiver: random stall, or a long hold-off when asked.
    always @(negedge clk)
    begin
        if (hold_off)
            rsp_stall <= 1'b1;
        else
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Watchdog on cycles with no transaction on either channel. Clearing
    // pass and the longest generations stay well inside the limit.
    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offer one command; valid stays high until the block takes it. The
    // block always stalls the cycle after an accept, so the drop of valid
    // between transactions costs nothing.
    task automatic send_command(cmd_t c);
        do
            @(negedge clk);
        while ($urandom_range(99) < send_idle_pct);
        cmd_valid <= 1'b1;
        cmd <= c;
        do
            @(posedge clk);
        while (cmd_stall);
        board.note_command(c);
        @(negedge clk);
        cmd_valid <= 1'b0;
    endtask

    task automatic send_fields(logic [1:0] m, int r, int c, bit a);
        cmd_t x;
        x.mode = m;
        x.row = 6'(r);
        x.col = 6'(c);
        x.alive = a;
        send_command(x);
    endtask

    task automatic wait_drained();
        while (board.pending_rsp.size() != 0)
            @(negedge clk);
    endtask

    // Mostly writes and reads around a small window, mixed at random with generations, mode three and writes anywhere.
    task automatic random_burst(int n);
        int br;
        int bc;
        int pick;
        br = $urandom_range(63);
        bc = $urandom_range(63);
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                send_fields(MODE_WRITE, (br + $urandom_range(4)) % 64,
                            (bc + $urandom_range(4)) % 64, $urandom_range(99) < 70);
            else if (pick < 65)
                send_fields(MODE_GEN, $urandom_range(63), $urandom_range(63),
                            $urandom_range(1));
            else if (pick < 92)
                send_fields(MODE_READ, (br + $urandom_range(4)) % 64,
                            (bc + $urandom_range(4)) % 64, $urandom_range(1));
            else if (pick < 96)
                send_fields(2'd3, $urandom_range(63), $urandom_range(63),
                            $urandom_range(1));
            else
                send_fields(MODE_WRITE, $urandom_range(63), $urandom_range(63),
                            $urandom_range(1));
        end
    endtask

    initial
    begin
        board = new();
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        rsp_stall = 1'b0;
        hold_off = 1'b0;
        quiet_cycles = 0;
        timed_out = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: corner writes, blinker, unchanged write, mode three.
        send_fields(MODE_WRITE, 0, 0, 1'b1);
        send_fields(MODE_WRITE, 0, 0, 1'b1);
        send_fields(MODE_WRITE, 63, 63, 1'b1);
        send_fields(MODE_READ, 62, 62, 1'b0);
        send_fields(MODE_READ, 1, 1, 1'b0);
        send_fields(MODE_WRITE, 10, 9, 1'b1);
        send_fields(MODE_WRITE, 10, 10, 1'b1);
        send_fields(MODE_WRITE, 10, 11, 1'b1);
        send_fields(MODE_GEN, 0, 0, 1'b0);
        send_fields(MODE_READ, 9, 10, 1'b0);
        send_fields(MODE_READ, 10, 10, 1'b0);
        send_fields(MODE_GEN, 63, 63, 1'b1);
        send_fields(MODE_READ, 10, 9, 1'b1);
        send_fields(MODE_WRITE, 63, 63, 1'b0);
        send_fields(MODE_WRITE, 0, 63, 1'b1);
        send_fields(MODE_WRITE, 63, 0, 1'b1);
        send_fields(2'd3, 42, 21, 1'b1);
        send_fields(MODE_GEN, 21, 42, 1'b0);
        send_fields(MODE_READ, 0, 0, 1'b1);
        send_fields(MODE_GEN, 0, 0, 1'b0);

        // Sender pauses until every response is back.
        wait_drained();

        // Long receiver hold-off while commands keep coming.
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(negedge clk);
                hold_off = 1'b0;
            end
            random_burst(4);
        join

        send_idle_pct = 30;
        recv_idle_pct = 87;
        random_burst(30);
        send_idle_pct = 87;
        recv_idle_pct = 30;
        random_burst(30);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_burst(30);

        wait_drained();
        repeat (50) @(negedge clk);
        if (board.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/lclg_pkg.sv
rtl/life_change_list_generation_top.sv
tb/sv/life_change_list_generation_top_test.sv
